/* sv/element_local_frame_macros.svh */
// Assertion macros for the element local frame block.
`ifndef ELEMENT_LOCAL_FRAME_MACROS_SVH
`define ELEMENT_LOCAL_FRAME_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ELF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ELF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ELF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ELF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/elf_pkg.sv */
// Shared constants for the element local frame block.
package elf_pkg;
  localparam int AxisOne = 16384;
  localparam int NormBits = 30;
  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_PLANE = 2'd1;
  localparam logic [1:0] KIND_BULK = 2'd2;
endpackage

/* sv/element_local_frame.sv */
// Element local frame: pipelined unit that turns three corners into a rotation matrix.
// It has 18 register stages. Throughput is one transfer per cycle; the square roots and
// divisions are spread over twelve stages of four steps each. The pipeline holds as a whole
// on an output stall.
// Reset clears the stage valid bits and sets material_kind to bulk.
`include "element_local_frame_macros.svh"
module element_local_frame import elf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // corner0_x, corner0_y, corner0_z, corner1_x..z, corner2_x..z from bit 0 up
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // axis_u_x..z, axis_v_x..z, axis_w_x..z, degenerate from bit 0 up
  output logic [151:0] m_axis_tdata
);
  localparam int Depth = 18;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } root_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [15:0] q;
  } quot_t;

  logic [1:0] material_kind;
  logic [Depth-1:0] vld;
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) material_kind <= KIND_BULK;
    else if (cfg_we) material_kind <= cfg_data;
  end

  // Helpers.
  function automatic logic [6:0] blen(input logic [69:0] m);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 70; i++) if (m[i]) n = 7'(i + 1);
    return n;
  endfunction
  function automatic logic signed [31:0] rn(input logic signed [70:0] v,
                                            input logic [6:0] top);
    logic [69:0] m;
    logic [69:0] s;
    m = v[70] ? 70'(-v) : v[69:0];
    if (top > 7'(NormBits)) s = m >> (top - 7'(NormBits));
    else s = m << (7'(NormBits) - top);
    return v[70] ? -$signed({2'b0, s[29:0]}) : $signed({2'b0, s[29:0]});
  endfunction
  function automatic logic [6:0] top3(input logic signed [70:0] a, b, c);
    logic [6:0] x, y, z, t;
    x = blen(a[70] ? 70'(-a) : a[69:0]);
    y = blen(b[70] ? 70'(-b) : b[69:0]);
    z = blen(c[70] ? 70'(-c) : c[69:0]);
    t = x;
    if (y > t) t = y;
    if (z > t) t = z;
    return t;
  endfunction
  // Four steps of the digit-by-digit square root, starting at step first.
  function automatic root_t root_steps(input logic [63:0] x_in, input logic [63:0] r_in,
                                       input int first);
    root_t o;
    logic [63:0] b;
    o.x = x_in;
    o.r = r_in;
    for (int k = 0; k < 4; k++) begin
      b = 64'd1 << (62 - 2 * (first + k));
      if (o.x >= o.r + b) begin
        o.x = o.x - (o.r + b);
        o.r = (o.r >> 1) + b;
      end else begin
        o.r = o.r >> 1;
      end
    end
    return o;
  endfunction
  // Four restoring division steps for quotient bits hi down to hi - 3.
  function automatic quot_t div_steps(input logic [47:0] rem_in, input logic [15:0] q_in,
                                      input logic [31:0] r, input int hi);
    quot_t o;
    logic [47:0] d;
    int k;
    o.rem = rem_in;
    o.q = q_in;
    for (int j = 0; j < 4; j++) begin
      k = hi - j;
      d = 48'(r) << k;
      if (o.rem >= d) begin
        o.rem = o.rem - d;
        o.q[4'(k)] = 1'b1;
      end
    end
    return o;
  endfunction

  // Stage 0: edges and provisional vector.
  logic signed [33:0] e1 [3], t0 [3];
  logic ok0;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [32:0] p [9];
      logic signed [33:0] d [3], t [3];
      for (int i = 0; i < 9; i++) p[i] = 33'(signed'(s_axis_tdata[32*i +: 32]));
      for (int i = 0; i < 3; i++) begin
        d[i] = 34'(p[3+i] - p[i]);
        t[i] = 34'(p[6+i] - p[3+i]);
      end
      if (material_kind == KIND_LINE) begin
        for (int i = 0; i < 3; i++) t[i] = '0;
        if (d[0] != 0 && d[1] == 0 && d[2] == 0) t[2] = 34'sd1;
        else if (d[1] != 0 && d[0] == 0 && d[2] == 0) t[0] = 34'sd1;
        else if (d[2] != 0 && d[0] == 0 && d[1] == 0) t[1] = 34'sd1;
        else if (d[0] != 0) t[0] = -d[0];
        else if (d[1] != 0) t[1] = -d[1];
        else if (d[2] != 0) t[2] = -d[2];
      end
      for (int i = 0; i < 3; i++) begin
        e1[i] <= d[i];
        t0[i] <= t[i];
      end
      ok0 <= (material_kind == KIND_LINE) || (material_kind == KIND_PLANE);
    end
  end

  // Stage 1: exact cross product and renormalized edge.
  logic signed [70:0] w1 [3];
  logic signed [31:0] un1 [3];
  logic ok1;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [6:0] tp;
      logic signed [70:0] ev [3];
      for (int i = 0; i < 3; i++) ev[i] = 71'(e1[i]);
      w1[0] <= 71'(e1[1] * t0[2]) - 71'(e1[2] * t0[1]);
      w1[1] <= 71'(e1[2] * t0[0]) - 71'(e1[0] * t0[2]);
      w1[2] <= 71'(e1[0] * t0[1]) - 71'(e1[1] * t0[0]);
      tp = top3(ev[0], ev[1], ev[2]);
      for (int i = 0; i < 3; i++) un1[i] <= rn(ev[i], tp);
      ok1 <= ok0 && tp != 0;
    end
  end

  // Stage 2: renormalized normal.
  logic signed [31:0] un2 [3], wn2 [3];
  logic ok2;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [6:0] tp;
      tp = top3(w1[0], w1[1], w1[2]);
      for (int i = 0; i < 3; i++) begin
        wn2[i] <= rn(w1[i], tp);
        un2[i] <= un1[i];
      end
      ok2 <= ok1 && tp != 0;
    end
  end

  // Stage 3: in-plane vector.
  logic signed [70:0] v3 [3];
  logic signed [31:0] un3 [3], wn3 [3];
  logic ok3;
  always_ff @(posedge clk) begin
    if (adv) begin
      v3[0] <= 71'(wn2[1] * un2[2]) - 71'(wn2[2] * un2[1]);
      v3[1] <= 71'(wn2[2] * un2[0]) - 71'(wn2[0] * un2[2]);
      v3[2] <= 71'(wn2[0] * un2[1]) - 71'(wn2[1] * un2[0]);
      for (int i = 0; i < 3; i++) begin
        un3[i] <= un2[i];
        wn3[i] <= wn2[i];
      end
      ok3 <= ok2;
    end
  end

  // Stage 4: renormalized in-plane vector.
  logic signed [31:0] c4 [9];
  logic ok4;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [6:0] tp;
      tp = top3(v3[0], v3[1], v3[2]);
      for (int i = 0; i < 3; i++) begin
        c4[i] <= un3[i];
        c4[3+i] <= rn(v3[i], tp);
        c4[6+i] <= wn3[i];
      end
      ok4 <= ok3 && tp != 0;
    end
  end

  // Stage 5: squared lengths.
  logic signed [31:0] c5 [9];
  logic [63:0] n5 [3];
  logic ok5;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++)
        n5[a] <= 64'(c4[3*a] * c4[3*a]) + 64'(c4[3*a+1] * c4[3*a+1]) +
                 64'(c4[3*a+2] * c4[3*a+2]);
      for (int i = 0; i < 9; i++) c5[i] <= c4[i];
      ok5 <= ok4;
    end
  end

  // Stages 6 to 13: square roots, four steps per stage.
  root_t rt [8][3];
  logic signed [31:0] cr [8][9];
  logic okr [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        rt[0][a] <= root_steps(n5[a], 64'd0, 0);
        for (int g = 1; g < 8; g++)
          rt[g][a] <= root_steps(rt[g-1][a].x, rt[g-1][a].r, 4 * g);
      end
      for (int i = 0; i < 9; i++) begin
        cr[0][i] <= c5[i];
        for (int g = 1; g < 8; g++) cr[g][i] <= cr[g-1][i];
      end
      okr[0] <= ok5;
      for (int g = 1; g < 8; g++) okr[g] <= okr[g-1];
    end
  end

  // Stages 14 to 16: rounded division of each magnitude by its length.
  quot_t dv [3][9];
  logic [31:0] dr [3][3];
  logic ds [3][9];
  logic okd [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [31:0] m;
      logic [47:0] n0;
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          m = cr[7][3*a+j][31] ? 32'(-cr[7][3*a+j]) : cr[7][3*a+j];
          n0 = 48'({m, 14'd0}) + 48'(rt[7][a].r[31:1]);
          dv[0][3*a+j] <= div_steps(n0, 16'd0, rt[7][a].r[31:0], 15);
          ds[0][3*a+j] <= cr[7][3*a+j][31];
          for (int g = 1; g < 3; g++) begin
            dv[g][3*a+j] <= div_steps(dv[g-1][3*a+j].rem, dv[g-1][3*a+j].q,
                                      dr[g-1][a], 15 - 4 * g);
            ds[g][3*a+j] <= ds[g-1][3*a+j];
          end
        end
        dr[0][a] <= rt[7][a].r[31:0];
        for (int g = 1; g < 3; g++) dr[g][a] <= dr[g-1][a];
      end
      okd[0] <= okr[7];
      for (int g = 1; g < 3; g++) okd[g] <= okd[g-1];
    end
  end

  // Stage 17: last quotient bits, sign and output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      quot_t f;
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          f = div_steps(dv[2][3*a+j].rem, dv[2][3*a+j].q, dr[2][a], 3);
          m_axis_tdata[16*(3*a+j) +: 16] <= !okd[2] ? 16'd0 :
                                            ds[2][3*a+j] ? 16'(-f.q) : f.q;
        end
      end
      m_axis_tdata[144] <= !okd[2];
      m_axis_tdata[151:145] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], s_axis_tvalid};
  end

  `ELF_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ELF_ASSERT_IMPL(a_ready, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `ELF_ASSERT_IMPL(a_pad, clk, rst, m_axis_tvalid, m_axis_tdata[151:145] == 7'd0)
endmodule
